>>> hdl/rgba16_pkg.sv
package rgba16_pkg;

  localparam int unsigned NumCh    = 4;
  localparam int unsigned NumStage = 8;
  localparam int unsigned AddrW    = 3;

  localparam logic [AddrW-1:0] AddrOpacity = 3'd0;
  localparam logic [AddrW-1:0] AddrMode    = 3'd4;

  localparam logic [30:0] Q31One  = 31'h7FFF_FFFF;
  localparam logic [62:0] Q31Half = 63'h3FFF_FFFF;
  localparam logic [15:0] ChMax   = 16'hFFFF;
  localparam logic [32:0] ChHalf  = 33'h7FFF;

  typedef enum logic {
    ModeStraight = 1'b0,
    ModePremul   = 1'b1
  } blend_mode_e;

  typedef struct packed {
    logic [NumCh-1:0][15:0] d;
    logic [NumCh-1:0][15:0] s;
    blend_mode_e            mode;
    logic                   pass;
    logic [61:0]            pq;
    logic [30:0]            q;
    logic [NumCh-1:0][46:0] pm;
    logic [NumCh-1:0][15:0] e;
    logic [NumCh-1:0][31:0] mul;
  } stage_t;

  // floor(x / (2^31-1)) via x = h*K + (h+l)
  function automatic logic [32:0] div_q31(input logic [62:0] x);
    logic [31:0] h;
    logic [32:0] t;
    logic [1:0]  c;
    h = x[62:31];
    t = {1'b0, h} + {2'b0, x[30:0]};
    if (t >= {1'b0, Q31One, 1'b0}) c = 2'd2;
    else if (t >= {2'b0, Q31One}) c = 2'd1;
    else c = 2'd0;
    return {1'b0, h} + {31'b0, c};
  endfunction

  // floor(x / 65535)
  function automatic logic [32:0] div_ch(input logic [32:0] x);
    logic [16:0] h;
    logic [17:0] t;
    logic [1:0]  c;
    h = x[32:16];
    t = {1'b0, h} + {2'b0, x[15:0]};
    if (t >= {1'b0, ChMax, 1'b0}) c = 2'd2;
    else if (t >= {2'b0, ChMax}) c = 2'd1;
    else c = 2'd0;
    return {16'b0, h} + {31'b0, c};
  endfunction

  function automatic logic [15:0] sat16(input logic [32:0] x);
    return (x > {17'b0, ChMax}) ? ChMax : x[15:0];
  endfunction

endpackage

>>> hdl/rgba16_source_over_blend_unit.sv
// Source-over compositing of 16-bit RGBA pixels, eight register stages deep.
// One pixel is accepted per clock while in_ready_o is high, and its result is
// presented from the last stage; throughput is one pixel per clock when the output
// does not stall, set by the pipelined multiply and divide-by-constant stages
// (coverage x opacity, alpha scale, premultiply, destination weight). Each stage
// holds its pixel while the next is full and stalled, so output stalls back up
// without loss. layer_opacity sits at address 0 and blend_mode at address 4;
// write them only while the pipeline is empty.
module rgba16_source_over_blend_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] dest_red_i,
  input  logic [15:0] dest_green_i,
  input  logic [15:0] dest_blue_i,
  input  logic [15:0] dest_alpha_i,
  input  logic [15:0] source_red_i,
  input  logic [15:0] source_green_i,
  input  logic [15:0] source_blue_i,
  input  logic [15:0] source_alpha_i,
  input  logic [30:0] pixel_coverage_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic [15:0] out_alpha_o
);

  logic [30:0]                 opacity_q;
  rgba16_pkg::blend_mode_e     mode_q;
  logic                        wr_en;

  rgba16_pkg::stage_t          st_q [rgba16_pkg::NumStage];
  rgba16_pkg::stage_t          st_d [rgba16_pkg::NumStage];
  logic [rgba16_pkg::NumStage-1:0] v_q;
  logic [rgba16_pkg::NumStage:0]   rdy;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= rgba16_pkg::Q31One;
      mode_q    <= rgba16_pkg::ModeStraight;
    end else if (wr_en) begin
      unique case (paddr)
        rgba16_pkg::AddrOpacity: opacity_q <= pwdata[30:0];
        rgba16_pkg::AddrMode:    mode_q    <= rgba16_pkg::blend_mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      rgba16_pkg::AddrOpacity: prdata = {1'b0, opacity_q};
      rgba16_pkg::AddrMode:    prdata = {31'b0, mode_q};
      default:                 prdata = 32'b0;
    endcase
  end

  // per-stage ready, a stage moves when empty or when its successor moves
  assign rdy[rgba16_pkg::NumStage] = out_ready_i;
  for (genvar k = 0; k < rgba16_pkg::NumStage; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    logic [32:0] a;
    logic [32:0] qd;
    logic [32:0] cd;
    qd = '0;
    cd = '0;
    st_d[0] = st_q[0];
    for (int k = 1; k < rgba16_pkg::NumStage; k++) begin
      st_d[k] = st_q[k-1];
    end

    // stage 1: capture and first products
    st_d[0].d    = {dest_alpha_i, dest_blue_i, dest_green_i, dest_red_i};
    st_d[0].s    = {source_alpha_i, source_blue_i, source_green_i, source_red_i};
    st_d[0].mode = mode_q;
    st_d[0].pq   = 62'(pixel_coverage_i) * 62'(opacity_q);
    for (int i = 0; i < rgba16_pkg::NumCh; i++) begin
      st_d[0].pm[i] = 47'(source_red_i) * 47'(opacity_q);
    end
    st_d[0].pm[1] = 47'(source_green_i) * 47'(opacity_q);
    st_d[0].pm[2] = 47'(source_blue_i) * 47'(opacity_q);
    st_d[0].pm[3] = 47'(source_alpha_i) * 47'(opacity_q);
    if (mode_q == rgba16_pkg::ModePremul) begin
      st_d[0].pass = (opacity_q == 31'd0);
    end else begin
      st_d[0].pass = (opacity_q == 31'd0) || (pixel_coverage_i == 31'd0);
    end

    // stage 2: q31 scale, premultiplied channels
    qd = rgba16_pkg::div_q31({1'b0, st_q[0].pq} + rgba16_pkg::Q31Half);
    st_d[1].q = qd[30:0];
    for (int i = 0; i < rgba16_pkg::NumCh; i++) begin
      st_d[1].e[i] = rgba16_pkg::sat16(
          rgba16_pkg::div_q31({16'b0, st_q[0].pm[i]} + rgba16_pkg::Q31Half));
    end

    // stage 3: alpha times scale
    st_d[2].pq = 62'(st_q[1].s[3]) * 62'(st_q[1].q);

    // stage 4: effective alpha
    a = rgba16_pkg::div_q31({1'b0, st_q[2].pq} + rgba16_pkg::Q31Half);
    if (st_q[2].mode == rgba16_pkg::ModeStraight) begin
      st_d[3].e[3] = rgba16_pkg::sat16(a);
      if (a == 33'd0) st_d[3].pass = 1'b1;
    end

    // stage 5: color times alpha
    for (int i = 0; i < rgba16_pkg::NumCh; i++) begin
      st_d[4].mul[i] = 32'(st_q[3].s[i]) * 32'(st_q[3].e[3]);
    end

    // stage 6: premultiplied color
    if (st_q[4].mode == rgba16_pkg::ModeStraight) begin
      for (int i = 0; i < rgba16_pkg::NumCh - 1; i++) begin
        cd = rgba16_pkg::div_ch({1'b0, st_q[4].mul[i]} + rgba16_pkg::ChHalf);
        st_d[5].e[i] = cd[15:0];
      end
    end

    // stage 7: destination weight
    for (int i = 0; i < rgba16_pkg::NumCh; i++) begin
      st_d[6].mul[i] = 32'(st_q[5].d[i]) * 32'(rgba16_pkg::ChMax - st_q[5].e[3]);
    end

    // stage 8: sum and saturate, or pass the destination through
    for (int i = 0; i < rgba16_pkg::NumCh; i++) begin
      if (st_q[6].pass) begin
        st_d[7].e[i] = st_q[6].d[i];
      end else begin
        st_d[7].e[i] = rgba16_pkg::sat16({17'b0, st_q[6].e[i]} +
            rgba16_pkg::div_ch({1'b0, st_q[6].mul[i]} + rgba16_pkg::ChHalf));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < rgba16_pkg::NumStage; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < rgba16_pkg::NumStage; k++) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  assign out_valid_o = v_q[rgba16_pkg::NumStage-1];
  assign out_red_o   = st_q[rgba16_pkg::NumStage-1].e[0];
  assign out_green_o = st_q[rgba16_pkg::NumStage-1].e[1];
  assign out_blue_o  = st_q[rgba16_pkg::NumStage-1].e[2];
  assign out_alpha_o = st_q[rgba16_pkg::NumStage-1].e[3];

endmodule

>>> hdl/rgba16_checker.sv
module rgba16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_red_o,
  input logic [15:0] out_alpha_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_red_o)
      && $stable(out_alpha_o))
    else $error("stalled output transfer changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // input only blocks when the output is backed up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with free output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (psel && penable && pwrite && paddr == rgba16_pkg::AddrOpacity) ##1
      (paddr == rgba16_pkg::AddrOpacity && !(psel && penable && pwrite))
      |-> prdata[30:0] == $past(pwdata[30:0]))
    else $error("opacity readback mismatch");

endmodule

bind rgba16_source_over_blend_unit rgba16_checker u_rgba16_checker (.*);
